@@ rtl/core/dhbd_pkg.sv @@
package dhbd_pkg;

  localparam int NUM_CLASSES_DEF = 80;

  localparam int LOGIT_W = 16;
  localparam int LABEL_W = 7;
  localparam int CELL_W  = 7;
  localparam int LEVEL_W = 2;
  localparam int DIST_W  = 16;
  localparam int PAD_W   = 10;
  localparam int SCALE_W = 16;
  localparam int CLIP_W  = 12;
  localparam int BOX_W   = 16;
  localparam int MASK_W  = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Queue depths between the front, the back and the result port.
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKED_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKED_MSK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_HALF_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_HALF_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RATIO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_X  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_Y  = 3'd7;

  // Pyramid level codes; any other code decodes as the coarsest level.
  localparam logic [LEVEL_W-1:0] LEVEL_S8  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_S16 = 2'd1;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] base_threshold;
    logic signed [LOGIT_W-1:0] tracked_threshold;
    logic [MASK_W-1:0]         tracked_mask;
    logic [PAD_W-1:0]          pad_half_x;
    logic [PAD_W-1:0]          pad_half_y;
    logic [SCALE_W-1:0]        scale_ratio;
    logic [CLIP_W-1:0]         clip_max_x;
    logic [CLIP_W-1:0]         clip_max_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_threshold:    -16'sd281,
    tracked_threshold: -16'sd562,
    tracked_mask:      64'd98305,
    pad_half_x:        10'd0,
    pad_half_y:        10'd0,
    scale_ratio:       16'd4096,
    clip_max_x:        12'd639,
    clip_max_y:        12'd639
  };

  // A detection that passed its threshold, waiting for box decode.
  typedef struct packed {
    logic [LABEL_W-1:0]        label;
    logic signed [LOGIT_W-1:0] score;
    logic [CELL_W-1:0]         cell_x;
    logic [CELL_W-1:0]         cell_y;
    logic [LEVEL_W-1:0]        level;
    logic signed [DIST_W-1:0]  dist_left;
    logic signed [DIST_W-1:0]  dist_top;
    logic signed [DIST_W-1:0]  dist_right;
    logic signed [DIST_W-1:0]  dist_bottom;
  } det_t;

  typedef struct packed {
    logic [LABEL_W-1:0]        label;
    logic signed [LOGIT_W-1:0] best_score;
    logic [BOX_W-1:0]          box_x;
    logic [BOX_W-1:0]          box_y;
    logic [BOX_W-1:0]          box_width;
    logic [BOX_W-1:0]          box_height;
  } result_t;

endpackage

@@ rtl/core/dhbd_fifo.sv @@
module dhbd_fifo
  import dhbd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign do_wr   = wr_en && (count_r != CW'(DEPTH));
  assign do_rd   = rd_en && (count_r != '0);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/dhbd_front.sv @@
module dhbd_front
  import dhbd_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      accept,
  input  logic signed [LOGIT_W-1:0] class_logit,
  input  logic                      last_class,
  input  logic [CELL_W-1:0]         cell_x,
  input  logic [CELL_W-1:0]         cell_y,
  input  logic [LEVEL_W-1:0]        level,
  input  logic signed [DIST_W-1:0]  dist_left,
  input  logic signed [DIST_W-1:0]  dist_top,
  input  logic signed [DIST_W-1:0]  dist_right,
  input  logic signed [DIST_W-1:0]  dist_bottom,
  output logic                      det_push,
  output det_t                      det
);

  localparam int CNT_W = $clog2(NUM_CLASSES + 1);

  logic signed [LOGIT_W-1:0] best_logit_r, cand_logit;
  logic [LABEL_W-1:0]        best_class_r, cand_class;
  logic [CNT_W-1:0]          class_count_r;
  logic                      take, tracked;
  logic signed [LOGIT_W-1:0] thr;

  // Logits past the class count are ignored; on a tie the first one wins.
  assign take = (class_count_r < CNT_W'(NUM_CLASSES));

  always_comb begin
    cand_logit = best_logit_r;
    cand_class = best_class_r;
    if (take && (class_count_r == '0 || class_logit > best_logit_r)) begin
      cand_logit = class_logit;
      cand_class = LABEL_W'(class_count_r);
    end
  end

  assign tracked  = !cand_class[LABEL_W-1] && cfg.tracked_mask[cand_class[5:0]];
  assign thr      = tracked ? cfg.tracked_threshold : cfg.base_threshold;
  assign det_push = accept && last_class && (cand_logit >= thr);

  always_comb begin
    det.label       = cand_class;
    det.score       = cand_logit;
    det.cell_x      = cell_x;
    det.cell_y      = cell_y;
    det.level       = level;
    det.dist_left   = dist_left;
    det.dist_top    = dist_top;
    det.dist_right  = dist_right;
    det.dist_bottom = dist_bottom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_logit_r  <= {1'b1, {(LOGIT_W-1){1'b0}}};
      best_class_r  <= '0;
      class_count_r <= '0;
    end else if (accept) begin
      if (last_class) begin
        best_logit_r  <= {1'b1, {(LOGIT_W-1){1'b0}}};
        best_class_r  <= '0;
        class_count_r <= '0;
      end else begin
        best_logit_r <= cand_logit;
        best_class_r <= cand_class;
        if (take) begin
          class_count_r <= class_count_r + CNT_W'(1);
        end
      end
    end
  end

endmodule

@@ rtl/core/dhbd_back.sv @@
module dhbd_back
  import dhbd_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           det_empty,
  input  det_t                           det,
  output logic                           det_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output result_t                        res
);

  localparam int OCW    = $clog2(OUT_DEPTH + 1);
  localparam int POS_W  = 24;
  localparam int PROD_W = POS_W + SCALE_W + 1;
  localparam int Q_W    = PROD_W - 16;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  logic                      va_r, vb_r;
  logic [LABEL_W-1:0]        label_a_r, label_b_r;
  logic signed [LOGIT_W-1:0] score_a_r, score_b_r;
  pos_t                      x0_a_r, y0_a_r, x1_a_r, y1_a_r;
  prod_t                     x0_b_r, y0_b_r, x1_b_r, y1_b_r;
  logic [OCW:0]              committed;
  logic [2:0]                shamt;
  logic signed [17:0]        cx, cy;
  logic [BOX_W-1:0]          bx0, by0, bx1, by1;
  logic signed [SCALE_W:0]   scale_s;

  // Edge in Q16.8 letterbox pixels, scaled by the stride, less the padding.
  function automatic pos_t edge_pos(input logic signed [17:0] p, input logic [2:0] sh,
                                    input logic [PAD_W-1:0] pad);
    pos_t s;
    s = pos_t'(p) <<< sh;
    return s - $signed({{(POS_W-PAD_W-8){1'b0}}, pad, 8'h00});
  endfunction

  // Round the Q21.20 product to Q12.4 and clip to [0, clip * 16].
  function automatic logic [BOX_W-1:0] clip_edge(input prod_t v, input logic [CLIP_W-1:0] c);
    prod_t            r;
    logic [Q_W-1:0]   q;
    logic [BOX_W-1:0] lim;
    r   = v + prod_t'(32768);
    q   = r[PROD_W-1:16];
    lim = {c, 4'h0};
    if (r[PROD_W-1]) begin
      return '0;
    end else if (q > Q_W'(lim)) begin
      return lim;
    end else begin
      return q[BOX_W-1:0];
    end
  endfunction

  // Results in flight plus those queued must fit the output queue.
  assign committed = (OCW+1)'(out_count) + (OCW+1)'(va_r) + (OCW+1)'(vb_r);
  assign det_pop   = !det_empty && (committed < (OCW+1)'(OUT_DEPTH));

  always_comb begin
    unique case (det.level)
      LEVEL_S8:  shamt = 3'd3;
      LEVEL_S16: shamt = 3'd4;
      default:   shamt = 3'd5;
    endcase
  end

  assign cx      = $signed({3'b000, det.cell_x, 8'h80});
  assign cy      = $signed({3'b000, det.cell_y, 8'h80});
  assign scale_s = $signed({1'b0, cfg.scale_ratio});

  always_ff @(posedge clk) begin
    if (det_pop) begin
      label_a_r <= det.label;
      score_a_r <= det.score;
      x0_a_r    <= edge_pos(cx - 18'(det.dist_left),   shamt, cfg.pad_half_x);
      y0_a_r    <= edge_pos(cy - 18'(det.dist_top),    shamt, cfg.pad_half_y);
      x1_a_r    <= edge_pos(cx + 18'(det.dist_right),  shamt, cfg.pad_half_x);
      y1_a_r    <= edge_pos(cy + 18'(det.dist_bottom), shamt, cfg.pad_half_y);
    end
    label_b_r <= label_a_r;
    score_b_r <= score_a_r;
    x0_b_r    <= prod_t'(x0_a_r) * prod_t'(scale_s);
    y0_b_r    <= prod_t'(y0_a_r) * prod_t'(scale_s);
    x1_b_r    <= prod_t'(x1_a_r) * prod_t'(scale_s);
    y1_b_r    <= prod_t'(y1_a_r) * prod_t'(scale_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= det_pop;
      vb_r <= va_r;
    end
  end

  assign bx0 = clip_edge(x0_b_r, cfg.clip_max_x);
  assign by0 = clip_edge(y0_b_r, cfg.clip_max_y);
  assign bx1 = clip_edge(x1_b_r, cfg.clip_max_x);
  assign by1 = clip_edge(y1_b_r, cfg.clip_max_y);

  assign res_push = vb_r;

  always_comb begin
    res.label      = label_b_r;
    res.best_score = score_b_r;
    res.box_x      = bx0;
    res.box_y      = by0;
    res.box_width  = (bx1 > bx0) ? bx1 - bx0 : '0;
    res.box_height = (by1 > by0) ? by1 - by0 : '0;
  end

endmodule

@@ rtl/core/detection_head_box_decode.sv @@
// Box decode for an anchor-free detection head.
// Input channel: one class logit per word, pushed with in_push while in_full is low.
// The word that carries in_last_class also carries the cell position, the pyramid
// level and the four box distances. A word is taken at every clock edge while
// in_full is low, and cells follow each other without a gap.
// Result channel: a cell whose best logit reaches its threshold yields one word,
// shown on the out_ ports while out_empty is low and taken with out_pop.
// A cell's result passes the middle queue, the back's a and b registers and the
// output queue before it is visible. Throughput: one result per cycle at most;
// the front argmax, the back decode pipeline (stride shift, scale multiply, round
// and clip) and the queues each run at one word per cycle unless a queue fills.
// When the receiver stalls, results gather in a four-word output queue and the
// four-word queue between the front and the back; once that fills, in_full rises.
// The user must write configuration words on the cfg_ channel (always ready) only
// while the block is idle, which the block does not enforce. Synchronous reset
// restores the register defaults and empties both queues and the running argmax.
module detection_head_box_decode
  import dhbd_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int MID_DEPTH   = MID_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic signed [LOGIT_W-1:0] in_class_logit,
  input  logic                      in_last_class,
  input  logic [CELL_W-1:0]         in_cell_x,
  input  logic [CELL_W-1:0]         in_cell_y,
  input  logic [LEVEL_W-1:0]        in_level,
  input  logic signed [DIST_W-1:0]  in_dist_left,
  input  logic signed [DIST_W-1:0]  in_dist_top,
  input  logic signed [DIST_W-1:0]  in_dist_right,
  input  logic signed [DIST_W-1:0]  in_dist_bottom,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [LABEL_W-1:0]        out_label,
  output logic signed [LOGIT_W-1:0] out_best_score,
  output logic [BOX_W-1:0]          out_box_x,
  output logic [BOX_W-1:0]          out_box_y,
  output logic [BOX_W-1:0]          out_box_width,
  output logic [BOX_W-1:0]          out_box_height,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  cfg_t    cfg_r;
  logic    in_accept;
  logic    det_push, det_pop, det_full, det_empty;
  det_t    det_in, det_out;
  logic    res_push;
  result_t res_in, res_out;
  logic [MCW-1:0] det_count;
  logic [OCW-1:0] res_count;
  logic           res_full;

  // Configuration registers. Writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCORE_THR:   cfg_r.base_threshold    <= cfg_data[LOGIT_W-1:0];
        REG_TRACKED_THR: cfg_r.tracked_threshold <= cfg_data[LOGIT_W-1:0];
        REG_TRACKED_MSK: cfg_r.tracked_mask      <= cfg_data[MASK_W-1:0];
        REG_PAD_HALF_X:  cfg_r.pad_half_x        <= cfg_data[PAD_W-1:0];
        REG_PAD_HALF_Y:  cfg_r.pad_half_y        <= cfg_data[PAD_W-1:0];
        REG_SCALE_RATIO: cfg_r.scale_ratio       <= cfg_data[SCALE_W-1:0];
        REG_CLIP_MAX_X:  cfg_r.clip_max_x        <= cfg_data[CLIP_W-1:0];
        REG_CLIP_MAX_Y:  cfg_r.clip_max_y        <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // The front never stalls on its own; it only waits for room in the queue.
  assign in_full   = det_full;
  assign in_accept = in_push && !det_full;

  dhbd_front #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .class_logit (in_class_logit),
    .last_class  (in_last_class),
    .cell_x      (in_cell_x),
    .cell_y      (in_cell_y),
    .level       (in_level),
    .dist_left   (in_dist_left),
    .dist_top    (in_dist_top),
    .dist_right  (in_dist_right),
    .dist_bottom (in_dist_bottom),
    .det_push    (det_push),
    .det         (det_in)
  );

  dhbd_fifo #(
    .WIDTH($bits(det_t)),
    .DEPTH(MID_DEPTH)
  ) u_det_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (det_push),
    .wr_data (det_in),
    .rd_en   (det_pop),
    .rd_data (det_out),
    .full    (det_full),
    .empty   (det_empty),
    .count   (det_count)
  );

  // The back only starts a decode when the output queue has a slot reserved.
  dhbd_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .det_empty (det_empty && (det_count == '0)),
    .det       (det_out),
    .det_pop   (det_pop),
    .out_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  dhbd_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push && !res_full),
    .wr_data (res_in),
    .rd_en   (out_pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (out_empty),
    .count   (res_count)
  );

  assign out_label      = res_out.label;
  assign out_best_score = res_out.best_score;
  assign out_box_x      = res_out.box_x;
  assign out_box_y      = res_out.box_y;
  assign out_box_width  = res_out.box_width;
  assign out_box_height = res_out.box_height;

endmodule
